/* hdl/ucc_pkg.sv */
`default_nettype none
package ucc_pkg;

    // Class table geometry
    localparam int UCC_CLASS_BITS  = 16;
    localparam int UCC_ENTRY_W     = 32;
    localparam int UCC_SPEC_W      = 16;
    localparam int UCC_TABLE_DEPTH = 256;
    localparam int UCC_QUEUE_DEPTH = 4;
    localparam int UCC_MAX_JOBS    = 3;

    localparam logic [7:0] CHAR_PCT = 8'h25;

    typedef enum logic [0:0] {
        JOB_WRITE = 1'b0,
        JOB_CHAR  = 1'b1
    } job_kind_t;

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_PCT   = 2'd1,
        PEND_DIGIT = 2'd2
    } pend_t;

    // One unit of work for the back end: a table write or one character to check
    typedef struct packed {
        job_kind_t              kind;
        logic [7:0]             ch;
        logic                   coded;
        logic [UCC_SPEC_W-1:0]  spec;
        logic                   comp_end;
        logic [UCC_ENTRY_W-1:0] entry;
    } job_t;

    function automatic logic is_hex(input logic [7:0] b);
        return ((b >= 8'h30) && (b <= 8'h39)) ||
               ((b >= 8'h41) && (b <= 8'h46)) ||
               ((b >= 8'h61) && (b <= 8'h66));
    endfunction

    // Valid hex digits only: letters have bit 6 set and map to low nibble + 9
    function automatic logic [3:0] hex_nibble(input logic [7:0] b);
        return b[6] ? (b[3:0] + 4'd9) : b[3:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h37 + {4'd0, nib});
    endfunction

    function automatic job_t mk_char(input logic [7:0] c, input logic coded,
                                     input logic [UCC_SPEC_W-1:0] spec);
        job_t j;
        j          = '0;
        j.kind     = JOB_CHAR;
        j.ch       = c;
        j.coded    = coded;
        j.spec     = spec;
        j.comp_end = 1'b0;
        return j;
    endfunction

endpackage
`default_nettype wire

/* hdl/ucc_front.sv */
`default_nettype none
module ucc_front import ucc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        s_tlast,
    output logic             q_valid,
    input  wire logic        q_ready,
    output job_t             q_data
);

    logic [7:0]            idx;
    logic [UCC_ENTRY_W-1:0] entry;
    logic [7:0]            b;
    logic [UCC_SPEC_W-1:0] spec;
    logic                  accept;
    logic                  b_hex;
    logic                  b_opens;
    logic [7:0]            decoded;

    pend_t       pend_reg, pend_next;
    logic [7:0]  digit_reg, digit_next;
    job_t        jobs_reg [UCC_MAX_JOBS];
    logic [1:0]  njobs_reg;
    job_t        cand [UCC_MAX_JOBS];
    logic [1:0]  ncand;
    logic        push_fire;

    assign idx     = s_tdata[7:0];
    assign entry   = s_tdata[39:8];
    assign b       = s_tdata[47:40];
    assign spec    = s_tdata[63:48];
    assign b_hex   = is_hex(b);
    assign b_opens = (b == CHAR_PCT) && !s_tlast;
    assign decoded = {hex_nibble(digit_reg), hex_nibble(b)};

    assign q_valid   = (njobs_reg != 2'd0);
    assign q_data    = jobs_reg[0];
    assign push_fire = q_valid && q_ready;
    assign s_tready  = (njobs_reg == 2'd0) || ((njobs_reg == 2'd1) && q_ready);
    assign accept    = s_tvalid && s_tready;

    // Escape tracking
    always_comb begin
        pend_next  = pend_reg;
        digit_next = digit_reg;
        if (accept && (s_tuser == JOB_CHAR)) begin
            unique case (pend_reg)
                PEND_NONE: begin
                    if (b_opens) pend_next = PEND_PCT;
                end
                PEND_PCT: begin
                    if (b_hex && !s_tlast) begin
                        pend_next  = PEND_DIGIT;
                        digit_next = b;
                    end else if (b_opens) begin
                        pend_next = PEND_PCT;
                    end else begin
                        pend_next = PEND_NONE;
                    end
                end
                PEND_DIGIT: begin
                    digit_next = '0;
                    if (!b_hex && b_opens) pend_next = PEND_PCT;
                    else                   pend_next = PEND_NONE;
                end
                default: begin
                    pend_next  = PEND_NONE;
                    digit_next = '0;
                end
            endcase
        end
    end

    // Break the item into character jobs
    always_comb begin
        logic consumed;
        consumed = 1'b0;
        ncand    = 2'd0;
        for (int i = 0; i < UCC_MAX_JOBS; i++) cand[i] = '0;
        if (s_tuser == JOB_WRITE) begin
            cand[0].kind  = JOB_WRITE;
            cand[0].ch    = idx;
            cand[0].entry = entry;
            ncand         = 2'd1;
        end else begin
            unique case (pend_reg)
                PEND_NONE: ;
                PEND_PCT: begin
                    if (b_hex && !s_tlast) begin
                        consumed = 1'b1;
                    end else begin
                        cand[0] = mk_char(CHAR_PCT, 1'b0, spec);
                        ncand   = 2'd1;
                    end
                end
                PEND_DIGIT: begin
                    if (b_hex) begin
                        cand[0]  = mk_char(decoded, 1'b1, spec);
                        ncand    = 2'd1;
                        consumed = 1'b1;
                    end else begin
                        cand[0] = mk_char(CHAR_PCT, 1'b0, spec);
                        cand[1] = mk_char(digit_reg, 1'b0, spec);
                        ncand   = 2'd2;
                    end
                end
                default: ;
            endcase
            if (!consumed && !b_opens) begin
                cand[ncand] = mk_char(b, 1'b0, spec);
                ncand       = ncand + 2'd1;
            end
            if (s_tlast && (ncand != 2'd0)) cand[ncand - 2'd1].comp_end = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= PEND_NONE;
            digit_reg <= '0;
            njobs_reg <= 2'd0;
        end else begin
            pend_reg  <= pend_next;
            digit_reg <= digit_next;
            if (accept) begin
                njobs_reg <= ncand;
            end else if (push_fire) begin
                njobs_reg <= njobs_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < UCC_MAX_JOBS; i++) jobs_reg[i] <= cand[i];
        end else if (push_fire) begin
            for (int i = 0; i < UCC_MAX_JOBS - 1; i++) jobs_reg[i] <= jobs_reg[i+1];
        end
    end

endmodule
`default_nettype wire

/* hdl/ucc_queue.sv */
`default_nettype none
module ucc_queue import ucc_pkg::*; #(
    parameter int DEPTH = UCC_QUEUE_DEPTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  job_t      in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output job_t      out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push, pop;

    assign in_ready  = (count_reg != FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= in_data;
    end

endmodule
`default_nettype wire

/* hdl/ucc_back.sv */
`default_nettype none
module ucc_back import ucc_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       q_valid,
    output logic            q_ready,
    input  job_t            q_data,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tuser,
    output logic            m_tlast
);

    logic [UCC_ENTRY_W-1:0] table_mem [UCC_TABLE_DEPTH];
    logic [UCC_ENTRY_W-1:0] rdata_reg;
    job_t                   job_reg;
    logic                   b_valid_reg;
    logic [1:0]             step_reg;
    logic                   drop_reg;
    logic                   m_tvalid_reg;
    logic [7:0]             m_tdata_reg;
    logic                   m_tuser_reg;
    logic                   m_tlast_reg;

    logic [UCC_ENTRY_W+UCC_SPEC_W-1:0] spec_wide;
    logic [UCC_ENTRY_W-1:0] esc, mask, hit;
    logic        bad, code, final_step, out_free, b_fire, b_done, emit, a_take;
    logic [7:0]  byte_out;

    // Character decision
    assign spec_wide = {{UCC_ENTRY_W{1'b0}}, job_reg.spec} << UCC_CLASS_BITS;
    assign esc       = spec_wide[UCC_ENTRY_W-1:0];
    assign mask      = {{(UCC_ENTRY_W-UCC_SPEC_W){1'b0}}, job_reg.spec} | esc;
    assign hit       = rdata_reg & mask;
    assign bad       = (hit == '0);
    assign code      = (hit == mask) ? job_reg.coded : ((rdata_reg & esc) != '0);

    assign final_step = drop_reg || bad || !code || (step_reg == 2'd2);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign b_fire     = b_valid_reg && (drop_reg || out_free);
    assign b_done     = b_fire && final_step;
    assign emit       = b_fire && !drop_reg;

    always_comb begin
        case (step_reg)
            2'd0:    byte_out = code ? CHAR_PCT : job_reg.ch;
            2'd1:    byte_out = hex_char(job_reg.ch[7:4]);
            default: byte_out = hex_char(job_reg.ch[3:0]);
        endcase
        if (bad) byte_out = '0;
    end

    // Table writes retire here; characters move on with their entry
    assign a_take  = q_valid && ((q_data.kind == JOB_WRITE) || !b_valid_reg || b_done);
    assign q_ready = a_take;

    always_ff @(posedge aclk) begin
        if (a_take && (q_data.kind == JOB_WRITE)) table_mem[q_data.ch] <= q_data.entry;
        if (a_take && (q_data.kind == JOB_CHAR)) begin
            rdata_reg <= table_mem[q_data.ch];
            job_reg   <= q_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg  <= 1'b0;
            step_reg     <= 2'd0;
            drop_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (a_take && (q_data.kind == JOB_CHAR)) b_valid_reg <= 1'b1;
            else if (b_done)                        b_valid_reg <= 1'b0;

            if (b_done)      step_reg <= 2'd0;
            else if (b_fire) step_reg <= step_reg + 2'd1;

            if (b_fire) begin
                if (drop_reg) begin
                    if (job_reg.comp_end) drop_reg <= 1'b0;
                end else if (bad && !job_reg.comp_end) begin
                    drop_reg <= 1'b1;
                end
            end

            if (emit)          m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= byte_out;
            m_tuser_reg <= bad;
            m_tlast_reg <= bad || (final_step && job_reg.comp_end);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_step_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !b_valid_reg |-> (step_reg == 2'd0))
        else $error("escape step counter runs with no character held");

    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg) |-> (m_tlast_reg && (m_tdata_reg == 8'd0)))
        else $error("error result must be a zero byte closing the component");

    a_drop_start: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(drop_reg) |-> (m_tvalid_reg && m_tuser_reg))
        else $error("dropping began without an error result");

    a_drop_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (drop_reg && b_valid_reg) |=> !(m_tvalid_reg && !$past(m_tvalid_reg)))
        else $error("result produced while dropping");

endmodule
`default_nettype wire

/* hdl/uri_component_canonicalizer.sv */
`default_nettype none
// URI component canonicalizer. Send class table writes (s_tuser = 0) and component
// bytes (s_tuser = 1, s_tlast on the final byte) on the slave stream; canonical text
// comes out on the master stream, one byte per transaction. Valid percent escapes in
// either hex case are decoded, checked against the 256-entry class table under the
// byte's component mask, and emitted raw or re-escaped in uppercase hex; broken escapes
// pass through literally. An illegal character ends the component with a single
// error transaction (m_tuser = 1, m_tlast = 1, m_tdata = 0) and the rest of that
// component is dropped. Load every table entry a component can reach before use: the
// table has no reset. Timing: the front end turns one byte into zero to three
// character jobs at one job per cycle while the queue accepts them; the back end does
// one table lookup per character and puts out one byte per cycle while m_tready
// allows, so a raw character yields one output byte and an escaped one three. Sustained
// throughput is set by the output port: one output byte per cycle. A table write
// passes the front end as a single job and retires in the back end.
module uri_component_canonicalizer import ucc_pkg::*; #(
    parameter int QUEUE_DEPTH = UCC_QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] table_index, [39:8] table_entry, [47:40] in_byte, [63:48] component_mask
    input  wire logic [63:0] s_tdata,
    // req_type: 0 table write, 1 component byte
    input  wire logic        s_tuser,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] out_byte
    output logic [7:0]       m_tdata,
    // illegal
    output logic             m_tuser,
    output logic             m_tlast
);

    // Front to queue
    logic fq_valid, fq_ready;
    job_t fq_data;
    // Queue to back
    logic qb_valid, qb_ready;
    job_t qb_data;

    // Front end: accept transactions, track pending escapes, split into jobs
    ucc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_data   (fq_data)
    );

    // Short job queue: decouple a stalled output from the input side
    ucc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    // Back end: hold the class table, classify each character, drive the result stream
    ucc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_data   (qb_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

/* bench/tb_uri_component_canonicalizer.sv */
`timescale 1ns / 1ps

module tb_uri_component_canonicalizer;
    import ucc_pkg::*;

    // Quiet cycles (nothing accepted on either side) before the run is declared hung.
    // The longest legal quiet stretch is the deliberate output hold-off below.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 20;

    // One slave-side transaction: a class table write or one component byte
    typedef struct {
        job_kind_t   kind;
        logic [7:0]  idx;
        logic [31:0] entry;
        logic [7:0]  ch;
        logic [15:0] spec;
        logic        last;
    } stim_t;

    // One master-side transaction
    typedef struct packed {
        logic [7:0] text;
        logic       last;
        logic       bad;
    } canon_out_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // Shadow of the block: class table, pending escape and the drop flag
    logic [31:0] class_shadow [256];
    pend_t       esc_state     = PEND_NONE;
    logic [7:0]  esc_digit     = '0;
    bit          skip_rest     = 1'b0;

    canon_out_t  canon_expect_q [$];
    canon_out_t  byte_results   [$];

    int          src_idle_pct  = 0;
    int          snk_idle_pct  = 0;
    bit          holdoff_req   = 1'b0;
    bit          holdoff_ack   = 1'b0;
    int          holdoff_left  = 0;
    int          quiet_cycles  = 0;
    int          err_count     = 0;

    uri_component_canonicalizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Canonical text predictor
    // ------------------------------------------------------------------

    function automatic bit hex_digit_ok(logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic logic [3:0] hex_digit_value(logic [7:0] b);
        logic [7:0] v;
        if (b >= "0" && b <= "9")
            v = b - "0";
        else if (b >= "a" && b <= "f")
            v = b - "a" + 8'd10;
        else
            v = b - "A" + 8'd10;
        return v[3:0];
    endfunction

    function automatic logic [7:0] upper_hex(logic [3:0] nib);
        string digits = "0123456789ABCDEF";
        return digits[nib];
    endfunction

    // Classify one character under the mask; append its text to byte_results.
    // Return 0 when the character is illegal (nothing appended).
    function automatic bit canon_char(logic [7:0] c, bit coded, logic [15:0] spec);
        logic [31:0] allow;
        logic [31:0] esc;
        logic [31:0] hit;
        logic [31:0] entry;
        bit          encode;
        allow = 32'(spec);
        esc   = allow << UCC_CLASS_BITS;
        entry = class_shadow[c];
        hit   = entry & (allow | esc);
        if (hit == '0)
            return 1'b0;
        // Both class halves hit: keep the escaping the character arrived with
        if (hit == (allow | esc))
            encode = coded;
        else
            encode = (entry & esc) != '0;
        if (encode) begin
            byte_results.push_back('{CHAR_PCT, 1'b0, 1'b0});
            byte_results.push_back('{upper_hex(c[7:4]), 1'b0, 1'b0});
            byte_results.push_back('{upper_hex(c[3:0]), 1'b0, 1'b0});
        end else begin
            byte_results.push_back('{c, 1'b0, 1'b0});
        end
        return 1'b1;
    endfunction

    // Advance the shadow by one accepted transaction and queue what it produces
    task automatic canon_predict(input stim_t it);
        bit         ok;
        bit         consumed;
        logic [7:0] decoded;
        ok       = 1'b1;
        consumed = 1'b0;
        byte_results.delete();
        if (it.kind == JOB_WRITE) begin
            class_shadow[it.idx] = it.entry;
            return;
        end
        // Rest of an aborted component: swallow up to and including its last byte
        if (skip_rest) begin
            if (it.last)
                skip_rest = 1'b0;
            return;
        end
        if (esc_state == PEND_PCT) begin
            if (hex_digit_ok(it.ch) && !it.last) begin
                esc_state = PEND_DIGIT;
                esc_digit = it.ch;
                return;
            end
            // Broken after the percent sign: flush it literally
            esc_state = PEND_NONE;
            ok = canon_char(CHAR_PCT, 1'b0, it.spec);
        end else if (esc_state == PEND_DIGIT) begin
            if (hex_digit_ok(it.ch)) begin
                decoded   = {hex_digit_value(esc_digit), hex_digit_value(it.ch)};
                esc_state = PEND_NONE;
                esc_digit = '0;
                ok        = canon_char(decoded, 1'b1, it.spec);
                consumed  = 1'b1;
            end else begin
                // Broken after one digit: flush percent and digit literally
                esc_state = PEND_NONE;
                ok = canon_char(CHAR_PCT, 1'b0, it.spec);
                if (ok)
                    ok = canon_char(esc_digit, 1'b0, it.spec);
                esc_digit = '0;
            end
        end
        // The breaking byte is handled afresh and may open a new escape
        if (ok && !consumed) begin
            if (it.ch == CHAR_PCT && !it.last)
                esc_state = PEND_PCT;
            else
                ok = canon_char(it.ch, 1'b0, it.spec);
        end
        if (!ok) begin
            esc_state = PEND_NONE;
            esc_digit = '0;
            byte_results.push_back('{8'h00, 1'b1, 1'b1});
            skip_rest = !it.last;
        end else if (it.last && byte_results.size() > 0) begin
            byte_results[$].last = 1'b1;
        end
        foreach (byte_results[k])
            canon_expect_q.push_back(byte_results[k]);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Fields that a table write ignores still get random values, and vice versa
    function automatic stim_t write_req(logic [7:0] idx, logic [31:0] entry);
        stim_t s;
        s.kind  = JOB_WRITE;
        s.idx   = idx;
        s.entry = entry;
        s.ch    = 8'($urandom);
        s.spec  = 16'($urandom);
        s.last  = 1'($urandom);
        return s;
    endfunction

    function automatic stim_t byte_req(logic [7:0] ch, logic [15:0] spec, logic last);
        stim_t s;
        s.kind  = JOB_CHAR;
        s.idx   = 8'($urandom);
        s.entry = $urandom;
        s.ch    = ch;
        s.spec  = spec;
        s.last  = last;
        return s;
    endfunction

    // Dense allowed half so that most characters pass under a small mask
    function automatic logic [31:0] rand_entry();
        logic [31:0] allow;
        logic [31:0] esc;
        allow = $urandom | $urandom;
        esc   = $urandom;
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            default: return {esc[15:0], allow[15:0]};
        endcase
    endfunction

    // Mostly one low class or two random classes, sometimes a wide random mask
    function automatic logic [15:0] rand_spec();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 16'h0001 << $urandom_range(0, 3);
        else if (r < 8)
            return (16'h0001 << $urandom_range(0, 15)) | (16'h0001 << $urandom_range(0, 15));
        else
            return 16'($urandom_range(1, 65535));
    endfunction

    function automatic logic [7:0] rand_hex_char();
        string digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    // Offer one transaction; enter and leave on a falling edge. Valid stays high
    // afterwards so that back-to-back transactions need no gap.
    task automatic send_item(input stim_t it);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.spec, it.ch, it.entry, it.idx};
        s_tuser  <= it.kind;
        s_tlast  <= it.last;
        do
            @(posedge aclk);
        while (!s_tready);
        canon_predict(it);
        @(negedge aclk);
    endtask

    // Hold the sender until every predicted byte has come out
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (canon_expect_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("%0t ns: %s: got %0h, want %0h", $time, what, got_v, want_v);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Load all 256 entries so that no lookup ever hits an unwritten one.
    // Printable characters other than space always allow class 0; NUL is never legal; 0xFF is
    // in every class of both halves.
    task automatic test_table_load();
        logic [31:0] entry;
        for (int i = 0; i < UCC_TABLE_DEPTH; i++) begin
            entry = rand_entry();
            if (i >= 8'h21 && i <= 8'h7e)
                entry[0] = 1'b1;
            if (i == 0)
                entry = '0;
            if (i == 8'hff)
                entry = '1;
            send_item(write_req(8'(i), entry));
        end
    endtask

    task automatic test_directed_cases();
        // 'A' raw only, space escape only, '~' and '%' keep their escaping
        send_item(write_req(8'h41, 32'h0000_0001));
        send_item(write_req(8'h20, 32'h0001_0000));
        send_item(write_req(8'h7e, 32'h0001_0001));
        send_item(write_req(CHAR_PCT, 32'h0001_0001));
        // Digit-only and lowercase escapes, forced escape, percent on the last byte
        send_item(byte_req(CHAR_PCT, 16'h0001, 1'b0));
        send_item(byte_req("4", 16'h0001, 1'b0));
        send_item(byte_req("1", 16'h0001, 1'b0));
        send_item(byte_req(CHAR_PCT, 16'h0001, 1'b0));
        send_item(byte_req("7", 16'h0001, 1'b0));
        send_item(byte_req("e", 16'h0001, 1'b0));
        send_item(byte_req(8'h20, 16'h0001, 1'b0));
        send_item(byte_req(CHAR_PCT, 16'h0001, 1'b1));
        // Broken after the percent, table write inside a pending escape,
        // broken after one digit
        send_item(byte_req(CHAR_PCT, 16'h0001, 1'b0));
        send_item(byte_req("G", 16'h0001, 1'b0));
        send_item(byte_req(CHAR_PCT, 16'h0001, 1'b0));
        send_item(write_req(8'h30, 32'h0001_0001));
        send_item(byte_req("4", 16'h0001, 1'b0));
        send_item(byte_req("z", 16'h0001, 1'b1));
        // Escape cut off by the last byte right after its percent sign
        send_item(byte_req(CHAR_PCT, 16'h0001, 1'b0));
        send_item(byte_req("4", 16'h0001, 1'b1));
        // Illegal character aborts; the rest of the component is dropped
        send_item(byte_req("A", 16'h0001, 1'b0));
        send_item(byte_req(8'h00, 16'h0001, 1'b0));
        send_item(byte_req("A", 16'h0001, 1'b0));
        send_item(byte_req("A", 16'h0001, 1'b1));
        // Empty mask makes everything illegal; widest mask on an all-ones entry
        send_item(byte_req("A", 16'h0000, 1'b1));
        send_item(byte_req(8'hff, 16'hffff, 1'b1));
    endtask

    // Well-formed components with random content: valid escapes in either case,
    // broken escapes, raw bytes, and the odd table rewrite between bytes
    task automatic test_random_traffic(input int n_items);
        int         sent;
        int         r;
        logic [15:0] spec;
        logic [7:0] comp [$];
        sent = 0;
        while (sent < n_items) begin
            comp.delete();
            spec = rand_spec();
            repeat ($urandom_range(1, 6)) begin
                r = $urandom_range(0, 19);
                if (r < 7) begin
                    comp.push_back(CHAR_PCT);
                    comp.push_back(rand_hex_char());
                    comp.push_back(rand_hex_char());
                end else if (r < 9) begin
                    comp.push_back(CHAR_PCT);
                    if ($urandom_range(0, 1))
                        comp.push_back(rand_hex_char());
                    comp.push_back(8'($urandom));
                end else if (r < 15) begin
                    comp.push_back(8'($urandom_range(8'h21, 8'h7e)));
                end else begin
                    comp.push_back(8'($urandom));
                end
            end
            foreach (comp[k]) begin
                if ($urandom_range(0, 24) == 0) begin
                    send_item(write_req(8'($urandom), rand_entry()));
                    sent++;
                end
                // Now and then switch context inside a component
                if ($urandom_range(0, 9) == 0)
                    spec = rand_spec();
                send_item(byte_req(comp[k], spec, k == comp.size() - 1));
                sent++;
            end
        end
    endtask

    // Stall the output long enough that the block backs up and drops s_tready,
    // then pause the sender until the block has drained
    task automatic test_output_holdoff();
        send_item(write_req(8'h20, 32'h0001_0000));
        holdoff_req = ~holdoff_req;
        repeat (15)
            send_item(byte_req(8'h20, 16'h0001, 1'b0));
        send_item(byte_req(8'h20, 16'h0001, 1'b1));
        wait_results_done();
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------

    // Drive m_tready at the falling edge; a hold-off request blocks it for a
    // fixed count of cycles
    always @(negedge aclk) begin
        if (holdoff_req != holdoff_ack) begin
            holdoff_ack  <= holdoff_req;
            holdoff_left <= HOLDOFF_CYCLES;
            m_tready     <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Compare every accepted output transaction with the oldest prediction
    always @(posedge aclk) begin
        canon_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (canon_expect_q.size() == 0) begin
                report_mismatch("unexpected output byte", m_tdata, 0);
            end else begin
                want = canon_expect_q.pop_front();
                if (m_tdata !== want.text)
                    report_mismatch("out_byte", m_tdata, want.text);
                if (m_tlast !== want.last)
                    report_mismatch("out_last", m_tlast, want.last);
                if (m_tuser !== want.bad)
                    report_mismatch("illegal", m_tuser, want.bad);
            end
        end
    end

    // Count cycles with no transaction on either side; give up when hung
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_uri_component_canonicalizer: errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_table_load();
        test_directed_cases();
        wait_results_done();

        // Sparse sender, heavily stalled receiver
        src_idle_pct = 25;
        snk_idle_pct = 81;
        test_random_traffic(4);

        // Swap the pressure
        src_idle_pct = 81;
        snk_idle_pct = 25;
        test_random_traffic(4);

        // Full rate on both sides
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_output_holdoff();
        test_random_traffic(4);

        // Drain, then give stray outputs time to show up
        wait_results_done();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (err_count == 0)
            $display("tb_uri_component_canonicalizer: clean");
        else
            $display("tb_uri_component_canonicalizer: errors");
        $finish;
    end

endmodule
